// ===== hdl/isort_pkg.sv =====
`default_nettype none

package isort_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;

    // control broadcast from the top level to every cell
    typedef struct packed {
        logic ins;    // insert the new value this cycle
        logic drain;  // shift the list down by one place
    } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/isort_cell.sv =====
`default_nettype none

module isort_cell #(
    parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire isort_pkg::ctrl_t      ctrl,
    input  wire logic [DATA_WIDTH-1:0] new_value,
    input  wire logic [DATA_WIDTH-1:0] left_value,
    input  wire logic                  left_valid,
    input  wire logic                  left_gt,
    input  wire logic [DATA_WIDTH-1:0] right_value,
    input  wire logic                  right_valid,
    output logic [DATA_WIDTH-1:0]      value,
    output logic                       valid,
    output logic                       gt
);

    logic [DATA_WIDTH-1:0] value_reg;
    logic [DATA_WIDTH-1:0] value_next;
    logic                  valid_reg;
    logic                  valid_next;

    // empty cell counts as larger than anything
    assign gt = !valid_reg || ($signed(value_reg) > $signed(new_value));

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.drain)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.ins)
        begin
            if (left_gt)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (gt)
            begin
                value_next = new_value;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

// ===== hdl/insertion_sort_engine_core.sv =====
// stable insertion sort of one set of signed values
//
// input stream (s_*): one element per request in s_tdata, s_tlast marks the
// final element of the set. output stream (m_*): the sorted set, ascending,
// one element per request, m_tlast on the final one, m_tuser set on every
// result of a set in which elements beyond CAPACITY were dropped
//
// a row of CAPACITY compare-and-shift cells holds the list; accepted
// elements are inserted as taken and enter at one per cycle while s_tready
// is high. equal elements keep arrival order. elements arriving at a full
// list are dropped and the overflow flag raised for that set
//
// after the request carrying s_tlast the results start on the next cycle,
// one per cycle while m_tready is high, the row shifting down one cell per
// result taken. s_tready stays low from the last element until the final
// result is taken. a stalled receiver simply holds the row: m_tdata comes
// straight from the first cell register
//
// reset empties the row and clears the overflow flag; no results pending
`default_nettype none

module insertion_sort_engine_core #(
    parameter int CAPACITY   = isort_pkg::CAPACITY,
    parameter int DATA_WIDTH = isort_pkg::DATA_WIDTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [isort_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    input  wire logic                          s_tlast,
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [isort_pkg::VALUE_W-1:0]      m_tdata,  // [31:0] value_res
    output logic                               m_tlast,
    output logic                               m_tuser   // [0] overflow
);

    localparam int VW = isort_pkg::VALUE_W;

    // handshake and control state
    logic emitting_reg;
    logic emitting_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_acc;
    logic out_acc;
    logic full;

    isort_pkg::ctrl_t ctrl;

    logic [DATA_WIDTH-1:0] new_value;
    logic [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic                  cell_valid [CAPACITY];
    logic                  cell_gt    [CAPACITY];

    // element taken in DATA_WIDTH bits: low bits kept, zero filled above
    generate
        if (DATA_WIDTH > VW)
        begin : g_in_wide
            assign new_value = {{(DATA_WIDTH-VW){1'b0}}, s_tdata};
        end
        else if (DATA_WIDTH == VW)
        begin : g_in_same
            assign new_value = s_tdata;
        end
        else
        begin : g_in_narrow
            assign new_value = s_tdata[DATA_WIDTH-1:0];
        end
    endgenerate

    assign s_tready = !emitting_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;

    // list full once the top cell holds an element
    assign full = cell_valid[CAPACITY-1];

    // fields in declaration order: ins, drain
    assign ctrl = {in_acc && !full, out_acc};

    // the row of cells, cell 0 holding the smallest element
    generate
        for (genvar i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_WIDTH-1:0] l_value;
            logic                  l_valid;
            logic                  l_gt;
            logic [DATA_WIDTH-1:0] r_value;
            logic                  r_valid;

            if (i == 0)
            begin : g_first
                assign l_value = '0;
                assign l_valid = 1'b0;
                assign l_gt    = 1'b0;
            end
            else
            begin : g_inner_l
                assign l_value = cell_value[i-1];
                assign l_valid = cell_valid[i-1];
                assign l_gt    = cell_gt[i-1];
            end

            if (i == CAPACITY-1)
            begin : g_top
                assign r_value = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner_r
                assign r_value = cell_value[i+1];
                assign r_valid = cell_valid[i+1];
            end

            isort_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .new_value   (new_value),
                .left_value  (l_value),
                .left_valid  (l_valid),
                .left_gt     (l_gt),
                .right_value (r_value),
                .right_valid (r_valid),
                .value       (cell_value[i]),
                .valid       (cell_valid[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    // drain phase: cell 0 always valid while emitting
    assign m_tvalid = emitting_reg;
    assign m_tlast  = !cell_valid[1];
    assign m_tuser  = dropped_reg;

    // result carries the low 32 bits of the stored element, zero filled
    generate
        if (DATA_WIDTH >= VW)
        begin : g_out_wide
            assign m_tdata = cell_value[0][VW-1:0];
        end
        else
        begin : g_out_narrow
            assign m_tdata = {{(VW-DATA_WIDTH){1'b0}}, cell_value[0]};
        end
    endgenerate

    always_comb
    begin
        emitting_next = emitting_reg;
        dropped_next  = dropped_reg;
        if (in_acc && full)
        begin
            dropped_next = 1'b1;
        end
        if (in_acc && s_tlast)
        begin
            emitting_next = 1'b1;
        end
        // final result of the set taken: list is empty again
        if (out_acc && m_tlast)
        begin
            emitting_next = 1'b0;
            dropped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emitting_reg <= 1'b0;
            dropped_reg  <= 1'b0;
        end
        else
        begin
            emitting_reg <= emitting_next;
            dropped_reg  <= dropped_next;
        end
    end

endmodule

`default_nettype wire
